// ===== rtl/core/jgsc_pkg.sv =====
// Shared types, codes and constants of the jog-and-goto stepper controller.
// Depends on nothing; every other file in rtl/core imports it.
package jgsc_pkg;

	localparam int POSITION_BITS = 32;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam int AGE_BITS      = 16;
	localparam int ANGLE_BITS    = 8;

	localparam logic [ANGLE_BITS-1:0] ANGLE_MAX = 8'd180;
	localparam logic [ANGLE_BITS-1:0] NUDGE_DEG = 8'd5;

	localparam logic [AGE_BITS-1:0]   JOG_TIMEOUT_RST = 16'd1290;
	localparam logic [AGE_BITS-1:0]   SERVO_HOLD_RST  = 16'd1613;
	localparam logic [ANGLE_BITS-1:0] SERVO_UP_RST    = 8'd10;
	localparam logic [ANGLE_BITS-1:0] SERVO_DOWN_RST  = 8'd120;

	typedef logic signed [POSITION_BITS-1:0] pos_t;

	typedef enum logic [3:0] {
		OP_NONE       = 4'd0,
		OP_JOG_UP     = 4'd1,
		OP_JOG_DOWN   = 4'd2,
		OP_STOP       = 4'd3,
		OP_SERVO_UP   = 4'd4,
		OP_SERVO_DOWN = 4'd5,
		OP_NUDGE_PLUS = 4'd6,
		OP_NUDGE_MIN  = 4'd7,
		OP_QUERY      = 4'd8,
		OP_GOTO       = 4'd9
	} op_t;

	typedef enum logic [2:0] {
		RPL_NONE       = 3'd0,
		RPL_SERVO_UP   = 3'd1,
		RPL_SERVO_DOWN = 3'd2,
		RPL_ANGLE      = 3'd3,
		RPL_POSITION   = 3'd4
	} reply_t;

	typedef enum logic [1:0] {
		JOG_STOPPED = 2'd0,
		JOG_UP      = 2'd1,
		JOG_DOWN    = 2'd2
	} jog_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_JOG_TIMEOUT = 2'd0,
		REG_SERVO_HOLD  = 2'd1,
		REG_SERVO_UP    = 2'd2,
		REG_SERVO_DOWN  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [3:0]         op;
		logic signed [31:0] goal;
	} cmd_t;

	typedef struct packed {
		logic               step_pulse;
		logic               dir_level;
		logic               servo_on;
		logic [7:0]         servo_deg;
		logic [2:0]         reply_kind;
		logic signed [31:0] reply_value;
		logic               arrived;
	} res_t;

	typedef struct packed {
		logic [AGE_BITS-1:0]   jog_timeout;
		logic [AGE_BITS-1:0]   servo_hold;
		logic [ANGLE_BITS-1:0] servo_up;
		logic [ANGLE_BITS-1:0] servo_down;
	} cfg_t;

	// clamp a one-bit-wider angle into 0..180
	function automatic logic [ANGLE_BITS-1:0] clamp_angle(input logic [ANGLE_BITS:0] deg);
		logic [ANGLE_BITS-1:0] r;
		if (deg > {1'b0, ANGLE_MAX})
			r = ANGLE_MAX;
		else
			r = deg[ANGLE_BITS-1:0];
		return r;
	endfunction

	function automatic logic [AGE_BITS-1:0] age_inc(input logic [AGE_BITS-1:0] a);
		logic [AGE_BITS-1:0] r;
		if (a == '1)
			r = a;
		else
			r = a + AGE_BITS'(1);
		return r;
	endfunction

endpackage

// ===== rtl/core/jgsc_cfg.sv =====
// Configuration register file: jog timeout, servo hold, servo up/down angles.
// Depends on jgsc_pkg.
module jgsc_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [jgsc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [jgsc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output jgsc_pkg::cfg_t                      cfg
);
	import jgsc_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.jog_timeout <= JOG_TIMEOUT_RST;
			cfg_q.servo_hold  <= SERVO_HOLD_RST;
			cfg_q.servo_up    <= SERVO_UP_RST;
			cfg_q.servo_down  <= SERVO_DOWN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_JOG_TIMEOUT: cfg_q.jog_timeout <= cfg_data;
				REG_SERVO_HOLD:  cfg_q.servo_hold  <= cfg_data;
				REG_SERVO_UP:    cfg_q.servo_up    <= cfg_data[ANGLE_BITS-1:0];
				REG_SERVO_DOWN:  cfg_q.servo_down  <= cfg_data[ANGLE_BITS-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/jgsc_slot.sv =====
// Controller state and the per-slot update: timers, jog/goto motion, servo.
// Depends on jgsc_pkg.
module jgsc_slot (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  jgsc_pkg::cmd_t  cmd,
	input  jgsc_pkg::cfg_t  cfg,
	output jgsc_pkg::res_t  res
);
	import jgsc_pkg::*;

	pos_t                  position_q;
	pos_t                  goal_q;
	logic                  goto_q;
	jog_t                  jog_q;
	logic [AGE_BITS-1:0]   jog_age_q;
	logic [ANGLE_BITS-1:0] angle_q;
	logic                  attached_q;
	logic [AGE_BITS-1:0]   servo_age_q;
	logic                  dir_q;

	pos_t                  position_d;
	pos_t                  goal_d;
	logic                  goto_d;
	jog_t                  jog_d;
	logic [AGE_BITS-1:0]   jog_age_d;
	logic [ANGLE_BITS-1:0] angle_d;
	logic                  attached_d;
	logic [AGE_BITS-1:0]   servo_age_d;
	logic                  dir_d;
	logic                  step;
	logic                  arrived;
	reply_t                kind;
	logic signed [31:0]    rval;
	logic [ANGLE_BITS-1:0] up_deg;
	logic [ANGLE_BITS-1:0] down_deg;

	assign up_deg   = clamp_angle({1'b0, cfg.servo_up});
	assign down_deg = clamp_angle({1'b0, cfg.servo_down});

	always_comb begin
		position_d  = position_q;
		goal_d      = goal_q;
		goto_d      = goto_q;
		jog_d       = jog_q;
		jog_age_d   = age_inc(jog_age_q);
		angle_d     = angle_q;
		attached_d  = attached_q;
		servo_age_d = age_inc(servo_age_q);
		dir_d       = dir_q;
		step        = 1'b0;
		arrived     = 1'b0;
		kind        = RPL_NONE;
		rval        = '0;

		unique case (cmd.op)
			OP_JOG_UP, OP_JOG_DOWN: begin
				jog_d     = (cmd.op == OP_JOG_UP) ? JOG_UP : JOG_DOWN;
				goto_d    = 1'b0;
				jog_age_d = '0;
			end
			OP_STOP: begin
				jog_d  = JOG_STOPPED;
				goto_d = 1'b0;
			end
			OP_SERVO_UP, OP_SERVO_DOWN: begin
				jog_d       = JOG_STOPPED;
				goto_d      = 1'b0;
				angle_d     = (cmd.op == OP_SERVO_UP) ? up_deg : down_deg;
				attached_d  = 1'b1;
				servo_age_d = '0;
				kind        = (cmd.op == OP_SERVO_UP) ? RPL_SERVO_UP : RPL_SERVO_DOWN;
			end
			OP_NUDGE_PLUS, OP_NUDGE_MIN: begin
				if (cmd.op == OP_NUDGE_PLUS)
					angle_d = clamp_angle({1'b0, angle_q} + {1'b0, NUDGE_DEG});
				else if (angle_q >= NUDGE_DEG)
					angle_d = angle_q - NUDGE_DEG;
				else
					angle_d = '0;
				attached_d  = 1'b1;
				servo_age_d = '0;
				kind        = RPL_ANGLE;
				rval        = 32'(angle_d);
			end
			OP_QUERY: begin
				kind = RPL_POSITION;
				rval = 32'(position_q);
			end
			OP_GOTO: begin
				goal_d = POSITION_BITS'(cmd.goal);
				goto_d = 1'b1;
				jog_d  = JOG_STOPPED;
			end
			default: ;
		endcase

		if (jog_d != JOG_STOPPED && jog_age_d > cfg.jog_timeout)
			jog_d = JOG_STOPPED;

		if (attached_d && servo_age_d > cfg.servo_hold)
			attached_d = 1'b0;

		// goto wins over jog
		if (goto_d) begin
			if (position_q != goal_d) begin
				step = 1'b1;
				if (position_q < goal_d) begin
					dir_d      = 1'b1;
					position_d = position_q + pos_t'(1);
				end else begin
					dir_d      = 1'b0;
					position_d = position_q - pos_t'(1);
				end
			end else begin
				goto_d  = 1'b0;
				arrived = 1'b1;
			end
		end else if (jog_d != JOG_STOPPED) begin
			step = 1'b1;
			if (jog_d == JOG_UP) begin
				dir_d      = 1'b1;
				position_d = position_q + pos_t'(1);
			end else begin
				dir_d      = 1'b0;
				position_d = position_q - pos_t'(1);
			end
		end

		res.step_pulse  = step;
		res.dir_level   = dir_d;
		res.servo_on    = attached_d;
		res.servo_deg   = angle_d;
		res.reply_kind  = kind;
		res.reply_value = rval;
		res.arrived     = arrived;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q  <= '0;
			goal_q      <= '0;
			goto_q      <= 1'b0;
			jog_q       <= JOG_STOPPED;
			jog_age_q   <= '0;
			angle_q     <= SERVO_UP_RST;
			attached_q  <= 1'b1;
			servo_age_q <= '0;
			dir_q       <= 1'b0;
		end else if (advance) begin
			position_q  <= position_d;
			goal_q      <= goal_d;
			goto_q      <= goto_d;
			jog_q       <= jog_d;
			jog_age_q   <= jog_age_d;
			angle_q     <= angle_d;
			attached_q  <= attached_d;
			servo_age_q <= servo_age_d;
			dir_q       <= dir_d;
		end
	end

	// a step always moves the position by one
	a_step_moves: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step |=> position_q != $past(position_q))
		else $error("step without position change");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		angle_q <= ANGLE_MAX)
		else $error("servo angle out of range");

	// arrival ends goto
	a_arrive_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && arrived |=> !goto_q)
		else $error("goto still active after arrival");

endmodule

// ===== rtl/core/jog_and_goto_stepper_controller_top.sv =====
// Top level of the jog-and-goto stepper controller: handshake and pipeline registers.
// Depends on jgsc_pkg, jgsc_cfg and jgsc_slot.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd): one beat per control slot, i.e.
//   one time tick; the beat may carry a command (op) and a goto target (goal).
//   res channel (res_valid / res_stall / res): exactly one result beat per
//   command beat, in order: step pulse, direction, servo state/angle, reply,
//   arrival flag.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register
//   writes, always ready; write only while no command is in flight.
// Timing: a command beat is captured in the input register; the slot logic then
//   updates the controller state and loads the result register once that register
//   is empty or draining. Throughput is one beat per cycle while res_stall is
//   low.
// Stall: when res_stall holds a pending result, the next command still enters
//   the input register; only when both registers are full does cmd_stall rise.
// Reset (arst_n low): position 0, jog stopped, no goto, servo attached at
//   10 degrees, registers at their defaults, both pipeline registers empty.
module jog_and_goto_stepper_controller_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  jgsc_pkg::cmd_t                      cmd,
	output logic                                res_valid,
	input  logic                                res_stall,
	output jgsc_pkg::res_t                      res,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [jgsc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [jgsc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import jgsc_pkg::*;

	cfg_t cfg;
	cmd_t item_s1;
	logic item_valid_s1;
	res_t res_s2;
	logic res_valid_s2;
	res_t slot_res;
	logic advance;

	// slot moves to the result register when that register is empty or draining
	assign advance   = item_valid_s1 && (!res_valid_s2 || !res_stall);
	assign cmd_stall = item_valid_s1 && !advance;
	assign res_valid = res_valid_s2;
	assign res       = res_s2;

	jgsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	jgsc_slot u_slot (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cmd     (item_s1),
		.cfg     (cfg),
		.res     (slot_res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			item_valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			item_s1 <= cmd;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= slot_res;
		end
	end

	// a refused command finds the input register still full next cycle
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |=> item_valid_s1)
		else $error("input register emptied under stall");

	// an item with a free result register always moves on
	a_item_moves: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid_s1 && !res_valid_s2 |=> res_valid_s2)
		else $error("item not forwarded to free result register");

	// stall only when both registers are occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> item_valid_s1 && res_valid_s2 && res_stall)
		else $error("command stalled with room in the pipeline");

endmodule

// ===== verif/tb_jog_and_goto_stepper_controller_top.sv =====
// Self-checking bench for jog_and_goto_stepper_controller_top: a slot predictor checks each
// result beat. Depends on jgsc_pkg and the top level in rtl/core.
`timescale 1ns / 100ps

module tb_jog_and_goto_stepper_controller_top;
	import jgsc_pkg::*;

	localparam int QUIET_LIMIT = 1000;  // cycles with no beat on any channel
	localparam int LONG_HOLD   = 80;    // receiver hold-off, well past the two-deep pipe
	localparam int MAX_PRINTS  = 30;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     cmd_valid = 1'b0;
	logic                     cmd_stall;
	cmd_t                     cmd       = '0;
	logic                     res_valid;
	logic                     res_stall = 1'b0;
	res_t                     res;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

	jog_and_goto_stepper_controller_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Controller shadow: config registers plus slot state
	// ------------------------------------------------------------------
	cfg_t       limits;
	pos_t       pos_m;
	pos_t       goal_m;
	logic       goto_m;
	jog_t       jog_m;
	logic [15:0] jog_age_m;
	logic [7:0] servo_deg_m;
	logic       servo_att_m;
	logic [15:0] servo_age_m;
	logic       dir_m;

	cmd_t cmd_backlog[$];       // slots waiting to be offered
	res_t expected_slots[$];    // predicted result beats, oldest first

	int   errors      = 0;
	int   results_in  = 0;
	logic cmd_taken   = 1'b0;   // beat on cmd went through at the last rising edge
	logic idle_on     = 1'b1;   // random idle bursts allowed on both sides
	int   send_gap    = 0;
	int   recv_gap    = 0;
	int   recv_hold   = 0;      // long receiver hold-off, counted down by the receiver
	int   quiet_cycles = 0;

	task automatic reset_shadow();
		limits.jog_timeout = JOG_TIMEOUT_RST;
		limits.servo_hold  = SERVO_HOLD_RST;
		limits.servo_up    = SERVO_UP_RST;
		limits.servo_down  = SERVO_DOWN_RST;
		pos_m       = '0;
		goal_m      = '0;
		goto_m      = 1'b0;
		jog_m       = JOG_STOPPED;
		jog_age_m   = '0;
		servo_deg_m = SERVO_UP_RST;
		servo_att_m = 1'b1;
		servo_age_m = '0;
		dir_m       = 1'b0;
	endtask

	// servo move: clamp to the top of the range, attach, restart the hold timer
	function automatic void servo_to(input logic [8:0] deg);
		servo_deg_m = (deg > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : deg[7:0];
		servo_att_m = 1'b1;
		servo_age_m = '0;
	endfunction

	// one control slot: age timers, apply command, timeouts, then motor move
	function automatic res_t step_controller_slot(input cmd_t c);
		res_t r;
		r = '0;
		if (jog_age_m != 16'hFFFF)
			jog_age_m++;
		if (servo_age_m != 16'hFFFF)
			servo_age_m++;

		case (c.op)
			OP_JOG_UP, OP_JOG_DOWN: begin
				jog_m     = (c.op == OP_JOG_UP) ? JOG_UP : JOG_DOWN;
				goto_m    = 1'b0;
				jog_age_m = '0;
			end
			OP_STOP: begin
				jog_m  = JOG_STOPPED;
				goto_m = 1'b0;
			end
			OP_SERVO_UP: begin
				jog_m  = JOG_STOPPED;
				goto_m = 1'b0;
				servo_to({1'b0, limits.servo_up});
				r.reply_kind = RPL_SERVO_UP;
			end
			OP_SERVO_DOWN: begin
				jog_m  = JOG_STOPPED;
				goto_m = 1'b0;
				servo_to({1'b0, limits.servo_down});
				r.reply_kind = RPL_SERVO_DOWN;
			end
			OP_NUDGE_PLUS: begin
				servo_to({1'b0, servo_deg_m} + {1'b0, NUDGE_DEG});
				r.reply_kind  = RPL_ANGLE;
				r.reply_value = {24'd0, servo_deg_m};
			end
			OP_NUDGE_MIN: begin
				servo_to((servo_deg_m >= NUDGE_DEG) ? {1'b0, servo_deg_m - NUDGE_DEG} : 9'd0);
				r.reply_kind  = RPL_ANGLE;
				r.reply_value = {24'd0, servo_deg_m};
			end
			OP_QUERY: begin
				r.reply_kind  = RPL_POSITION;
				r.reply_value = pos_m;  // position before this slot's step
			end
			OP_GOTO: begin
				goal_m = c.goal;
				goto_m = 1'b1;
				jog_m  = JOG_STOPPED;
			end
			default: ;  // unused codes are plain ticks
		endcase

		if (jog_m != JOG_STOPPED && jog_age_m > limits.jog_timeout)
			jog_m = JOG_STOPPED;
		if (servo_att_m && servo_age_m > limits.servo_hold)
			servo_att_m = 1'b0;

		// goto wins over jog
		if (goto_m) begin
			if (pos_m != goal_m) begin
				dir_m = (pos_m < goal_m);
				pos_m = dir_m ? pos_m + 1 : pos_m - 1;
				r.step_pulse = 1'b1;
			end else begin
				goto_m    = 1'b0;
				r.arrived = 1'b1;
			end
		end else if (jog_m != JOG_STOPPED) begin
			dir_m = (jog_m == JOG_UP);
			pos_m = dir_m ? pos_m + 1 : pos_m - 1;
			r.step_pulse = 1'b1;
		end

		r.dir_level = dir_m;
		r.servo_on  = servo_att_m;
		r.servo_deg = servo_deg_m;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("%0t: result beat %0d: %s got 0x%08h expected 0x%08h",
				$realtime, results_in, what, got, want);
	endtask

	task automatic check_result(input res_t got, input res_t want);
		if (got.step_pulse !== want.step_pulse)
			report_mismatch("step_pulse", got.step_pulse, want.step_pulse);
		if (got.dir_level !== want.dir_level)
			report_mismatch("dir_level", got.dir_level, want.dir_level);
		if (got.servo_on !== want.servo_on)
			report_mismatch("servo_on", got.servo_on, want.servo_on);
		if (got.servo_deg !== want.servo_deg)
			report_mismatch("servo_deg", got.servo_deg, want.servo_deg);
		if (got.reply_kind !== want.reply_kind)
			report_mismatch("reply_kind", got.reply_kind, want.reply_kind);
		if (got.reply_value !== want.reply_value)
			report_mismatch("reply_value", got.reply_value, want.reply_value);
		if (got.arrived !== want.arrived)
			report_mismatch("arrived", got.arrived, want.arrived);
	endtask

	// Monitor: both channels sampled at the rising edge, before the DUT's
	// registers update. A cmd beat runs the predictor; a res beat is checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				expected_slots.push_back(step_controller_slot(cmd));
				cmd_taken = 1'b1;
			end
			if (res_valid && !res_stall) begin
				results_in++;
				if (expected_slots.size() == 0)
					report_mismatch("beat with nothing expected", res.reply_value, '0);
				else
					check_result(res, expected_slots.pop_front());
			end
		end
	end

	// Driver: moves on only once the offered beat has gone through, so a
	// stalled payload holds still and valid never looks at stall.
	always @(negedge clk) begin
		if (arst_n && (!cmd_valid || cmd_taken)) begin
			cmd_taken = 1'b0;
			if (send_gap == 0 && idle_on && $urandom_range(0, 9) == 0)
				send_gap = $urandom_range(1, 7);
			if (send_gap > 0) begin
				send_gap--;
				cmd_valid <= 1'b0;
			end else if (cmd_backlog.size() != 0) begin
				cmd_valid <= 1'b1;
				cmd       <= cmd_backlog.pop_front();
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Receiver: long hold-off when asked, else random stall bursts
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			recv_hold--;
			res_stall <= 1'b1;
		end else if (recv_gap > 0) begin
			recv_gap--;
			res_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 11) == 0) begin
			recv_gap  = $urandom_range(0, 6);
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Watchdog: any beat on any channel counts as progress
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_jog_and_goto_stepper_controller_top: FAIL");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic add_cmd(input logic [3:0] op, input logic [31:0] goal);
		cmd_t c;
		c.op   = op;
		c.goal = goal;
		cmd_backlog.push_back(c);
	endtask

	// register write; the shadow follows at the edge where it lands
	task automatic write_reg(input reg_idx_t idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_JOG_TIMEOUT: limits.jog_timeout = data;
			REG_SERVO_HOLD:  limits.servo_hold  = data;
			REG_SERVO_UP:    limits.servo_up    = data[7:0];
			REG_SERVO_DOWN:  limits.servo_down  = data[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(input logic [15:0] jog_to, input logic [15:0] hold,
			input logic [15:0] up, input logic [15:0] down);
		write_reg(REG_JOG_TIMEOUT, jog_to);
		write_reg(REG_SERVO_HOLD, hold);
		write_reg(REG_SERVO_UP, up);
		write_reg(REG_SERVO_DOWN, down);
	endtask

	// sampled at rising edges so the backlog, valid and expectations agree
	task automatic wait_idle();
		while (cmd_backlog.size() != 0 || cmd_valid || expected_slots.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Random traffic built mostly from meaningful runs: jogs left to time out,
	// gotos near home that arrive, nudge runs into the angle limits.
	task automatic gen_traffic(input int n, input int span);
		int   made;
		int   k;
		logic [3:0] op;
		logic signed [31:0] tgt;
		made = 0;
		while (made < n) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					op = $urandom_range(0, 1) ? OP_JOG_UP : OP_JOG_DOWN;
					add_cmd(op, $urandom);
					k = $urandom_range(1, span);
					repeat (k) begin
						case ($urandom_range(0, 9))
							0: add_cmd(op, $urandom);        // refresh the jog
							1: add_cmd(OP_QUERY, $urandom);
							default: add_cmd(OP_NONE, $urandom);
						endcase
					end
					made += k + 1;
				end
				3, 4: begin
					tgt = $urandom_range(0, 80);
					tgt = tgt - 40;
					add_cmd(OP_GOTO, tgt);
					k = $urandom_range(0, 50);
					repeat (k)
						add_cmd(($urandom_range(0, 5) == 0) ? OP_QUERY : OP_NONE, $urandom);
					made += k + 1;
				end
				5: begin
					add_cmd(4'($urandom_range(OP_SERVO_UP, OP_NUDGE_MIN)), $urandom);
					made++;
				end
				6: begin
					add_cmd(4'($urandom_range(0, 15)), $urandom);
					made++;
				end
				7: begin
					// far target: exercises the signed compare, then abandoned
					add_cmd(OP_GOTO, $urandom);
					k = $urandom_range(0, 4);
					repeat (k) add_cmd(OP_NONE, $urandom);
					add_cmd(OP_STOP, $urandom);
					made += k + 2;
				end
				8: begin
					add_cmd($urandom_range(0, 1) ? OP_STOP : OP_QUERY, $urandom);
					made++;
				end
				default: begin
					op = $urandom_range(0, 1) ? OP_NUDGE_PLUS : OP_NUDGE_MIN;
					k = $urandom_range(1, 40);
					repeat (k) add_cmd(op, $urandom);
					made += k;
				end
			endcase
		end
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		reset_shadow();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed pass at reset defaults.
		add_cmd(OP_NONE, 32'h0);
		add_cmd(OP_QUERY, 32'h0);
		add_cmd(OP_GOTO, 32'd0);          // already there: arrives with no step
		add_cmd(OP_GOTO, 32'd3);
		repeat (3) add_cmd(OP_NONE, 32'hFFFF_FFFF);
		add_cmd(OP_GOTO, 32'd5);
		add_cmd(OP_NONE, 32'h0);
		add_cmd(OP_QUERY, 32'h0);         // query lands on the arrival slot
		add_cmd(OP_JOG_UP, 32'h0);
		add_cmd(OP_NONE, 32'h0);
		add_cmd(OP_JOG_DOWN, 32'h0);
		add_cmd(OP_NONE, 32'h0);
		add_cmd(OP_STOP, 32'h0);
		add_cmd(OP_SERVO_DOWN, 32'h0);
		add_cmd(OP_NUDGE_PLUS, 32'h0);
		add_cmd(OP_NUDGE_MIN, 32'h0);
		add_cmd(OP_SERVO_UP, 32'h0);
		add_cmd(4'd10, 32'hFFFF_FFFF);    // unused codes tick only
		add_cmd(4'd15, 32'h5555_AAAA);
		add_cmd(OP_GOTO, 32'h7FFF_FFFF);
		add_cmd(OP_STOP, 32'h0);
		add_cmd(OP_GOTO, 32'h8000_0000);
		add_cmd(OP_QUERY, 32'h0);
		add_cmd(OP_STOP, 32'h0);
		wait_idle();

		// Extremes: zero timeouts, angles at both ends of the range.
		write_all(16'd0, 16'd0, 16'd0, 16'd180);
		add_cmd(OP_JOG_UP, 32'h0);
		add_cmd(OP_NONE, 32'h0);          // zero timeout: jog ends here
		add_cmd(OP_NONE, 32'h0);
		add_cmd(OP_SERVO_UP, 32'h0);
		add_cmd(OP_NUDGE_MIN, 32'h0);     // clamps at 0
		add_cmd(OP_NONE, 32'h0);          // zero hold: servo detaches
		add_cmd(OP_SERVO_DOWN, 32'h0);
		add_cmd(OP_NUDGE_PLUS, 32'h0);    // clamps at 180
		gen_traffic(150, 4);
		wait_idle();

		// An angle register beyond 180 and upper data bits that fall away.
		// The receiver holds off long enough to back the block up.
		write_all(16'd5, 16'd12, 16'hFFFF, 16'hA52D);
		@(posedge clk);
		recv_hold = LONG_HOLD;
		gen_traffic(170, 9);
		wait_idle();

		// Random settings; the sender pauses midway for a full drain.
		write_all(16'($urandom_range(1, 40)), 16'($urandom_range(0, 40)),
			{8'($urandom), 8'($urandom_range(0, 255))},
			{8'($urandom), 8'($urandom_range(0, 255))});
		gen_traffic(125, int'(limits.jog_timeout) + 4);
		wait_idle();
		gen_traffic(125, int'(limits.jog_timeout) + 4);
		wait_idle();

		// Saturated timers: neither the jog nor the servo may ever time out.
		// Then walk back home so later gotos stay short.
		idle_on = 1'b0;
		write_reg(REG_JOG_TIMEOUT, 16'hFFFF);
		write_reg(REG_SERVO_HOLD, 16'hFFFF);
		add_cmd(OP_SERVO_DOWN, 32'h0);
		add_cmd(OP_JOG_UP, 32'h0);
		repeat (30) add_cmd(OP_NONE, 32'h0);
		add_cmd(OP_QUERY, 32'h0);
		add_cmd(OP_GOTO, 32'd0);
		repeat (40) add_cmd(OP_NONE, 32'h0);
		add_cmd(OP_QUERY, 32'h0);
		wait_idle();

		// Closing stretch without idling.
		write_all(16'($urandom_range(0, 20)), 16'($urandom_range(0, 30)),
			16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)));
		gen_traffic(150, int'(limits.jog_timeout) + 4);
		wait_idle();

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("tb_jog_and_goto_stepper_controller_top: PASS");
		else
			$display("tb_jog_and_goto_stepper_controller_top: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/jgsc_pkg.sv
rtl/core/jgsc_cfg.sv
rtl/core/jgsc_slot.sv
rtl/core/jog_and_goto_stepper_controller_top.sv
verif/tb_jog_and_goto_stepper_controller_top.sv
